/* rtl/ccs_pkg.sv */
// Shared types and character constants for the C comment stripper.
`default_nettype none

package ccs_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Depth of the command queue between front and back.
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_EOL
  } ccs_op_e;

  // One classified request: an optional held slash to keep first, then one operation.
  typedef struct packed {
    logic       slash;
    ccs_op_e    op;
    logic [7:0] ch;
    logic       empty;
  } ccs_cmd_t;

endpackage

`default_nettype wire

/* rtl/ccs_front.sv */
// Front scanner: tracks literal and comment modes and classifies each character.
`default_nettype none

module ccs_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic            eol_i,
  output logic                 enq_o,
  output ccs_pkg::ccs_cmd_t    cmd_o
);
  import ccs_pkg::*;

  localparam logic [1:0] MODE_CODE  = 2'd0;
  localparam logic [1:0] MODE_SQ    = 2'd1;
  localparam logic [1:0] MODE_DQ    = 2'd2;
  localparam logic [1:0] MODE_BLOCK = 2'd3;

  logic [1:0] mode_q, mode_d;
  logic       held_q, held_d;
  logic       skip_q, skip_d;
  logic       lc_q, lc_d;
  logic       has_q, has_d;
  logic       do_code;
  logic [7:0] quote;

  always_comb begin
    mode_d     = mode_q;
    held_d     = held_q;
    skip_d     = skip_q;
    lc_d       = lc_q;
    has_d      = has_q;
    do_code    = 1'b0;
    quote      = (mode_q == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
    cmd_o.slash = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.ch    = ch_i;
    cmd_o.empty = !has_q;
    if (acc_i) begin
      if (eol_i) begin
        cmd_o.slash = held_q && (mode_q == MODE_CODE);
        cmd_o.op    = OP_EOL;
        held_d      = 1'b0;
        skip_d      = 1'b0;
        lc_d        = 1'b0;
        has_d       = 1'b0;
      end else begin
        has_d = 1'b1;
        if (lc_q) begin
          has_d = 1'b1;
        end else if (mode_q == MODE_BLOCK) begin
          if (held_q && ch_i == CH_SLASH) begin
            mode_d = MODE_CODE;
            held_d = 1'b0;
          end else begin
            held_d = (ch_i == CH_STAR);
          end
        end else if (mode_q == MODE_SQ || mode_q == MODE_DQ) begin
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (ch_i == quote) begin
            mode_d = MODE_CODE;
          end else if (ch_i == CH_BSLASH) begin
            skip_d = 1'b1;
          end
          cmd_o.op = OP_CHAR;
        end else if (held_q) begin
          held_d = 1'b0;
          if (ch_i == CH_SLASH) begin
            lc_d = 1'b1;
          end else if (ch_i == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end else begin
            // The held slash was an ordinary character after all.
            cmd_o.slash = 1'b1;
            do_code     = 1'b1;
          end
        end else begin
          do_code = 1'b1;
        end

        if (do_code) begin
          if (ch_i == CH_SQUOTE) begin
            mode_d   = MODE_SQ;
            cmd_o.op = OP_CHAR;
          end else if (ch_i == CH_DQUOTE) begin
            mode_d   = MODE_DQ;
            cmd_o.op = OP_CHAR;
          end else if (ch_i == CH_SLASH) begin
            held_d = 1'b1;
          end else begin
            cmd_o.op = OP_CHAR;
          end
        end
      end
    end
  end

  assign enq_o = acc_i && (cmd_o.slash || cmd_o.op != OP_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      held_q <= 1'b0;
      skip_q <= 1'b0;
      lc_q   <= 1'b0;
      has_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      held_q <= held_d;
      skip_q <= skip_d;
      lc_q   <= lc_d;
      has_q  <= has_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/ccs_queue.sv */
// Short command queue that decouples the front scanner from the back emitter.
`default_nettype none

module ccs_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              enq_i,
  input  wire ccs_pkg::ccs_cmd_t cmd_i,
  input  wire logic              deq_i,
  output ccs_pkg::ccs_cmd_t      head_o,
  output logic                   vld_o,
  output logic                   full_o
);
  import ccs_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  ccs_cmd_t        mem_q [QDEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;
  logic            do_enq, do_deq;

  assign do_enq = enq_i && !full_o;
  assign do_deq = deq_i && vld_o;
  assign vld_o  = (cnt_q != '0);
  assign full_o = (cnt_q == CW'(QDEPTH));
  assign head_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_enq) begin
        wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_deq) begin
        rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(do_enq) - CW'(do_deq);
    end
  end

endmodule

`default_nettype wire

/* rtl/ccs_back.sv */
// Back emitter: holds leading blanks, decides kept lines and drives the result register.
`default_nettype none

module ccs_back #(
  parameter int unsigned BLANK_MAX = 62
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccs_pkg::ccs_cmd_t head_i,
  input  wire logic              vld_i,
  output logic                   deq_o,
  input  wire logic              pop_i,
  output logic                   out_vld_o,
  output logic [7:0]             out_ch_o,
  output logic                   out_eol_o,
  output logic                   overflow_o,
  output logic                   last_o
);
  import ccs_pkg::*;

  localparam int unsigned CW = $clog2(BLANK_MAX + 1);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                 state_q, state_d;
  logic                 kept_q, kept_d;
  logic                 sdone_q, sdone_d;
  logic                 fovf_q, fovf_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [BLANK_MAX-1:0] kinds_q, kinds_d;

  logic                 vld_q;
  logic [7:0]           ch_q;
  logic                 eol_q, ovf_q, last_q;

  logic                 out_free, step;
  logic                 part_slash, cur_eol, cur_last, cur_blank, part_done;
  logic [7:0]           cur_ch;
  logic                 emit, e_eol, e_ovf, e_last;
  logic [7:0]           e_ch;

  assign out_free   = !vld_q || pop_i;
  assign step       = vld_i && out_free;
  assign part_slash = head_i.slash && !sdone_q;
  assign cur_ch     = part_slash ? CH_SLASH : head_i.ch;
  assign cur_eol    = !part_slash && (head_i.op == OP_EOL);
  assign cur_last   = part_slash ? (head_i.op == OP_NONE) : 1'b1;
  assign cur_blank  = (cur_ch == CH_SPACE) || (cur_ch == CH_TAB);

  always_comb begin
    state_d   = state_q;
    kept_d    = kept_q;
    sdone_d   = sdone_q;
    fovf_d    = fovf_q;
    cnt_d     = cnt_q;
    kinds_d   = kinds_q;
    part_done = 1'b0;
    emit      = 1'b0;
    e_ch      = cur_ch;
    e_eol     = 1'b0;
    e_ovf     = 1'b0;
    e_last    = 1'b0;
    if (step) begin
      if (state_q == ST_FLUSH) begin
        if (cnt_q != '0) begin
          emit    = 1'b1;
          e_ch    = kinds_q[0] ? CH_TAB : CH_SPACE;
          e_ovf   = fovf_q;
          kinds_d = kinds_q >> 1;
          cnt_d   = cnt_q - CW'(1);
        end else begin
          emit      = 1'b1;
          e_ovf     = fovf_q;
          e_last    = cur_last;
          kept_d    = kept_q || !fovf_q;
          state_d   = ST_RUN;
          part_done = 1'b1;
        end
      end else if (cur_eol) begin
        emit      = kept_q || head_i.empty;
        e_ch      = '0;
        e_eol     = 1'b1;
        e_last    = 1'b1;
        kept_d    = 1'b0;
        cnt_d     = '0;
        kinds_d   = '0;
        part_done = 1'b1;
      end else if (cur_blank && !kept_q) begin
        if (cnt_q != CW'(BLANK_MAX)) begin
          kinds_d   = kinds_q | (BLANK_MAX'(cur_ch == CH_TAB) << cnt_q);
          cnt_d     = cnt_q + CW'(1);
          part_done = 1'b1;
        end else begin
          // A full buffer goes out undecided, followed by this blank.
          state_d = ST_FLUSH;
          fovf_d  = 1'b1;
        end
      end else if (!kept_q && cnt_q != '0) begin
        state_d = ST_FLUSH;
        fovf_d  = 1'b0;
      end else begin
        emit      = 1'b1;
        e_last    = cur_last;
        kept_d    = 1'b1;
        part_done = 1'b1;
      end

      if (part_done) begin
        sdone_d = part_slash && (head_i.op != OP_NONE);
      end
    end
  end

  assign deq_o = part_done && !sdone_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      kept_q  <= 1'b0;
      sdone_q <= 1'b0;
      fovf_q  <= 1'b0;
      cnt_q   <= '0;
      kinds_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kept_q  <= kept_d;
      sdone_q <= sdone_d;
      fovf_q  <= fovf_d;
      cnt_q   <= cnt_d;
      kinds_q <= kinds_d;
      if (emit) begin
        vld_q <= 1'b1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ch_q   <= e_ch;
      eol_q  <= e_eol;
      ovf_q  <= e_ovf;
      last_q <= e_last;
    end
  end

  assign out_vld_o  = vld_q;
  assign out_ch_o   = ch_q;
  assign out_eol_o  = eol_q;
  assign overflow_o = ovf_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

/* rtl/c_comment_stripper.sv */
// C comment stripper: the scanner front takes one character or line end per cycle while
// full is low and classifies it into a request for a two-entry queue; the back part turns
// each request into results at most one per cycle through its result register while results
// are popped. A request yields at most one result of its own, or two when a held slash
// proves to be an ordinary character, after any leading blanks it releases. Input stalls
// (full high) when the queue fills, as when a blank flush or an unpopped result side holds
// up the back part. Results carry last on the final result caused by an input item.
`default_nettype none

module c_comment_stripper #(
  parameter int unsigned BLANK_MAX = 62
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] ch_i,
  input  wire logic       eol_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_ch_o,
  output logic            out_eol_o,
  output logic            overflow_o,
  output logic            last_o
);
  import ccs_pkg::*;

  logic     acc, enq, deq, head_vld, q_full, out_vld;
  ccs_cmd_t cmd, head;

  assign full  = q_full;
  assign acc   = push && !q_full;
  assign empty = !out_vld;

  ccs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .ch_i   (ch_i),
    .eol_i  (eol_i),
    .enq_o  (enq),
    .cmd_o  (cmd)
  );

  ccs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .cmd_i  (cmd),
    .deq_i  (deq),
    .head_o (head),
    .vld_o  (head_vld),
    .full_o (q_full)
  );

  ccs_back #(
    .BLANK_MAX (BLANK_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .vld_i      (head_vld),
    .deq_o      (deq),
    .pop_i      (pop),
    .out_vld_o  (out_vld),
    .out_ch_o   (out_ch_o),
    .out_eol_o  (out_eol_o),
    .overflow_o (overflow_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

/* rtl/ccs_checker.sv */
// Port-level checks for the C comment stripper and their binding to the top level.
`default_nettype none

module ccs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_ch_o,
  input wire logic       out_eol_o,
  input wire logic       overflow_o,
  input wire logic       last_o
);

  // A newline always closes the results of its request.
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_eol_o) |-> (last_o && out_ch_o == 8'h00))
    else $error("newline result not last or carries a character");

  // Overflowed blanks are never line ends.
  a_ovf_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> (!out_eol_o && (out_ch_o == 8'h20 || out_ch_o == 8'h09)))
    else $error("overflow result is not a blank");

  // An overflowed blank that is not last is followed by another overflowed blank.
  a_ovf_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && overflow_o && !last_o) |=> (empty || overflow_o))
    else $error("overflow burst broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_ch_o) && $stable(out_eol_o) &&
                          $stable(overflow_o) && $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_ch_o   (out_ch_o),
  .out_eol_o  (out_eol_o),
  .overflow_o (overflow_o),
  .last_o     (last_o)
);

`default_nettype wire
